@@ rtl/assert_macros.svh @@
// Assertion macros for the rasterizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define TDR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define TDR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/tdr_pkg.sv @@
// ----------------------------------------------------------------------------
// tdr_pkg
// Shared widths, the queued pixel job and helpers for the rasterizer.
// ----------------------------------------------------------------------------
package tdr_pkg;

  localparam int SCR_W   = 512;
  localparam int SCR_H   = 512;
  localparam int PX_W    = $clog2(SCR_W);
  localparam int PY_W    = $clog2(SCR_H);
  localparam int ADDR_W  = PX_W + PY_W;
  localparam int CELLS   = SCR_W * SCR_H;
  localparam int COORD_W = 11;
  localparam int DEPTH_W = 16;
  localparam int SHADE_W = 24;

  localparam logic [0:0] CMD_LOAD = 1'b0;
  localparam logic [0:0] CMD_STEP = 1'b1;

  localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};
  localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};

  // One pixel to evaluate, with the triangle it belongs to.
  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [DEPTH_W-1:0] az;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [DEPTH_W-1:0] bz;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [DEPTH_W-1:0] cz;
    logic [SHADE_W-1:0]        shade;
    logic [PX_W-1:0]           px;
    logic [PY_W-1:0]           py;
    logic                      last;
  } tdr_job_t;

  // Queue status seen by the front end and the pixel unit
  typedef struct packed {
    logic full;
    logic empty;
  } tdr_q_stat_t;

  function automatic logic [PX_W-1:0] clamp_x(input logic signed [COORD_W-1:0] v);
    logic [PX_W-1:0] r;
    if (v < 0) r = '0;
    else if (v > $signed(COORD_W'(SCR_W - 1))) r = PX_W'(SCR_W - 1);
    else r = v[PX_W-1:0];
    return r;
  endfunction

  function automatic logic [PY_W-1:0] clamp_y(input logic signed [COORD_W-1:0] v);
    logic [PY_W-1:0] r;
    if (v < 0) r = '0;
    else if (v > $signed(COORD_W'(SCR_H - 1))) r = PY_W'(SCR_H - 1);
    else r = v[PY_W-1:0];
    return r;
  endfunction

endpackage

@@ rtl/tdr_queue.sv @@
// ----------------------------------------------------------------------------
// tdr_queue
// Two-entry job queue between the traversal front end and the pixel unit.
// ----------------------------------------------------------------------------
module tdr_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  tdr_pkg::tdr_job_t     push_job,
  input  logic                  pop,
  output tdr_pkg::tdr_job_t     pop_job,
  output tdr_pkg::tdr_q_stat_t  stat
);

  tdr_pkg::tdr_job_t ent_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_job;
  end

  assign pop_job    = ent_r[rp_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

endmodule

@@ rtl/tdr_front.sv @@
// ----------------------------------------------------------------------------
// tdr_front
// Takes input beats: latches triangles, walks the bounding box, queues pixels.
// ----------------------------------------------------------------------------
module tdr_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clearing,
  input  tdr_pkg::tdr_q_stat_t  q_stat,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [143:0]          in_tdata,
  input  logic                  in_tuser,
  output logic                  push,
  output tdr_pkg::tdr_job_t     push_job
);

  logic signed [tdr_pkg::COORD_W-1:0] ax, ay, bx, by, cx, cy;
  logic signed [tdr_pkg::DEPTH_W-1:0] az, bz, cz;
  logic [tdr_pkg::SHADE_W-1:0]        shade;

  tdr_pkg::tdr_job_t tri_r, tri_nxt;
  logic [tdr_pkg::PX_W-1:0] xmin_r, xmax_r, cur_x_r;
  logic [tdr_pkg::PX_W-1:0] xmin_nxt, xmax_nxt, cur_x_nxt;
  logic [tdr_pkg::PY_W-1:0] ymin_r, ymax_r, cur_y_r;
  logic [tdr_pkg::PY_W-1:0] ymin_nxt, ymax_nxt, cur_y_nxt;
  logic busy_r, busy_nxt;

  logic signed [tdr_pkg::COORD_W-1:0] mnx, mxx, mny, mxy;
  logic [tdr_pkg::PY_W:0] y_inc;
  logic [tdr_pkg::PX_W:0] x_inc;
  logic acc, row_end, box_end;

  assign ax    = in_tdata[10:0];
  assign ay    = in_tdata[21:11];
  assign az    = in_tdata[37:22];
  assign bx    = in_tdata[48:38];
  assign by    = in_tdata[59:49];
  assign bz    = in_tdata[75:60];
  assign cx    = in_tdata[86:76];
  assign cy    = in_tdata[97:87];
  assign cz    = in_tdata[113:98];
  assign shade = in_tdata[137:114];

  assign in_tready = !clearing && !q_stat.full;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    mnx = (ax < bx) ? ax : bx;  mnx = (mnx < cx) ? mnx : cx;
    mxx = (ax > bx) ? ax : bx;  mxx = (mxx > cx) ? mxx : cx;
    mny = (ay < by) ? ay : by;  mny = (mny < cy) ? mny : cy;
    mxy = (ay > by) ? ay : by;  mxy = (mxy > cy) ? mxy : cy;
  end

  always_comb begin
    y_inc   = {1'b0, cur_y_r} + 1'b1;
    x_inc   = {1'b0, cur_x_r} + 1'b1;
    row_end = (y_inc >= {1'b0, ymax_r});
    box_end = row_end && (x_inc >= {1'b0, xmax_r});

    tri_nxt   = tri_r;
    xmin_nxt  = xmin_r;
    xmax_nxt  = xmax_r;
    ymin_nxt  = ymin_r;
    ymax_nxt  = ymax_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    busy_nxt  = busy_r;
    push      = 1'b0;

    push_job      = tri_r;
    push_job.px   = cur_x_r;
    push_job.py   = cur_y_r;
    push_job.last = box_end;

    if (acc && in_tuser == tdr_pkg::CMD_LOAD) begin
      tri_nxt.ax = ax;  tri_nxt.ay = ay;  tri_nxt.az = az;
      tri_nxt.bx = bx;  tri_nxt.by = by;  tri_nxt.bz = bz;
      tri_nxt.cx = cx;  tri_nxt.cy = cy;  tri_nxt.cz = cz;
      tri_nxt.shade = shade;
      xmin_nxt  = tdr_pkg::clamp_x(mnx);
      xmax_nxt  = tdr_pkg::clamp_x(mxx);
      ymin_nxt  = tdr_pkg::clamp_y(mny);
      ymax_nxt  = tdr_pkg::clamp_y(mxy);
      cur_x_nxt = xmin_nxt;
      cur_y_nxt = ymin_nxt;
      busy_nxt  = (xmin_nxt < xmax_nxt) && (ymin_nxt < ymax_nxt);
    end else if (acc && busy_r) begin
      push = 1'b1;
      if (row_end) begin
        cur_y_nxt = ymin_r;
        cur_x_nxt = x_inc[tdr_pkg::PX_W-1:0];
        if (box_end) busy_nxt = 1'b0;
      end else begin
        cur_y_nxt = y_inc[tdr_pkg::PY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tri_r   <= '0;
      xmin_r  <= '0;
      xmax_r  <= '0;
      ymin_r  <= '0;
      ymax_r  <= '0;
      cur_x_r <= '0;
      cur_y_r <= '0;
      busy_r  <= 1'b0;
    end else begin
      tri_r   <= tri_nxt;
      xmin_r  <= xmin_nxt;
      xmax_r  <= xmax_nxt;
      ymin_r  <= ymin_nxt;
      ymax_r  <= ymax_nxt;
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule

@@ rtl/tdr_back.sv @@
// ----------------------------------------------------------------------------
// tdr_back
// Pixel unit: edge functions, depth interpolation, divider, depth store.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tdr_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tdr_pkg::tdr_q_stat_t  q_stat,
  input  tdr_pkg::tdr_job_t     pop_job,
  output logic                  pop,
  output logic                  clearing,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata,
  output logic                  out_tlast,
  output logic                  out_tuser
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_DIFF   = 10'b0000000010,
    ST_PROD   = 10'b0000000100,
    ST_CROSS  = 10'b0000001000,
    ST_WEIGHT = 10'b0000010000,
    ST_SUM    = 10'b0000100000,
    ST_ABS    = 10'b0001000000,
    ST_DIV    = 10'b0010000000,
    ST_FIX    = 10'b0100000000,
    ST_WRITE  = 10'b1000000000
  } st_t;

  localparam int AW = tdr_pkg::ADDR_W;
  localparam int DW = tdr_pkg::DEPTH_W;

  st_t st_r, st_nxt;
  tdr_pkg::tdr_job_t job_r;

  logic signed [11:0] ux_r, vx_r, wx_r, uy_r, vy_r, wy_r;
  logic signed [23:0] p1_r, p2_r, p3_r, p4_r, p5_r, p6_r;
  logic signed [24:0] mx_r, my_r, mz_r;
  logic signed [26:0] ma_r;
  logic signed [42:0] wa_r, wb_r, wc_r;
  logic signed [44:0] num_r;
  logic               inside_r, neg_r;
  logic [44:0]        rem_r;
  logic [24:0]        dvs_r;
  logic [3:0]         cnt_r;
  logic [15:0]        q_r;
  logic signed [DW-1:0] d_r, rd_data_r;
  logic               wr_r;

  logic [AW-1:0] clr_cnt_r;
  logic          clearing_r;

  logic [DW-1:0] mem [tdr_pkg::CELLS];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, job_addr;
  logic [DW-1:0] mem_wd;

  logic        out_valid_r, out_free;
  logic [47:0] out_data_r;
  logic        out_last_r, out_user_r;

  logic [45:0]        trial;
  logic signed [16:0] qs;
  logic               in_x, in_y, in_a;

  assign clearing = clearing_r;
  assign out_free = !out_valid_r || out_tready;
  assign pop      = (st_r == ST_IDLE) && !clearing_r && !q_stat.empty;
  assign job_addr = {job_r.py, job_r.px};

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:   if (pop) st_nxt = ST_DIFF;
      ST_DIFF:   st_nxt = ST_PROD;
      ST_PROD:   st_nxt = ST_CROSS;
      ST_CROSS:  st_nxt = ST_WEIGHT;
      ST_WEIGHT: st_nxt = ST_SUM;
      ST_SUM:    st_nxt = ST_ABS;
      ST_ABS:    st_nxt = ST_DIV;
      ST_DIV:    if (cnt_r == 4'd0) st_nxt = ST_FIX;
      ST_FIX:    st_nxt = ST_WRITE;
      ST_WRITE:  if (out_free) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else        st_r <= st_nxt;
  end

  // datapath, one step per state
  always_comb begin
    trial = {1'b0, rem_r} - ({21'b0, dvs_r} << cnt_r);
    qs    = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
    in_x  = (mx_r == 0) || ((mx_r > 0) == (mz_r > 0));
    in_y  = (my_r == 0) || ((my_r > 0) == (mz_r > 0));
    in_a  = (ma_r == 0) || ((ma_r > 0) == (mz_r > 0));
  end

  always_ff @(posedge clk) begin
    if (pop) job_r <= pop_job;
    case (st_r)
      ST_DIFF: begin
        ux_r <= 12'(job_r.bx) - 12'(job_r.ax);
        vx_r <= 12'(job_r.cx) - 12'(job_r.ax);
        wx_r <= 12'(job_r.ax) - $signed({3'b0, job_r.px});
        uy_r <= 12'(job_r.by) - 12'(job_r.ay);
        vy_r <= 12'(job_r.cy) - 12'(job_r.ay);
        wy_r <= 12'(job_r.ay) - $signed({3'b0, job_r.py});
      end
      ST_PROD: begin
        p1_r <= vx_r * wy_r;
        p2_r <= wx_r * vy_r;
        p3_r <= wx_r * uy_r;
        p4_r <= ux_r * wy_r;
        p5_r <= ux_r * vy_r;
        p6_r <= vx_r * uy_r;
      end
      ST_CROSS: begin
        mx_r <= 25'(p1_r) - 25'(p2_r);
        my_r <= 25'(p3_r) - 25'(p4_r);
        mz_r <= 25'(p5_r) - 25'(p6_r);
        ma_r <= (27'(p5_r) - 27'(p6_r)) - (27'(p1_r) - 27'(p2_r))
                - (27'(p3_r) - 27'(p4_r));
      end
      ST_WEIGHT: begin
        inside_r <= (mz_r != 0) && in_x && in_y && in_a;
        wa_r <= 43'(job_r.az) * 43'(ma_r);
        wb_r <= 43'(job_r.bz) * 43'(mx_r);
        wc_r <= 43'(job_r.cz) * 43'(my_r);
      end
      ST_SUM: num_r <= 45'(wa_r) + 45'(wb_r) + 45'(wc_r);
      ST_ABS: begin
        rem_r <= num_r[44] ? 45'(-num_r) : 45'(num_r);
        dvs_r <= mz_r[24] ? 25'(-mz_r) : 25'(mz_r);
        neg_r <= num_r[44] ^ mz_r[24];
        cnt_r <= 4'd15;
        q_r   <= '0;
      end
      ST_DIV: begin
        // restoring step, one quotient bit a cycle
        if (!trial[45]) begin
          rem_r      <= trial[44:0];
          q_r[cnt_r] <= 1'b1;
        end
        cnt_r <= cnt_r - 4'd1;
      end
      ST_FIX: begin
        if (qs > 17'(tdr_pkg::DEPTH_MAX))      d_r <= tdr_pkg::DEPTH_MAX;
        else if (qs < 17'(tdr_pkg::DEPTH_MIN)) d_r <= tdr_pkg::DEPTH_MIN;
        else                                   d_r <= qs[DW-1:0];
      end
      ST_WRITE: ;
      default: ;
    endcase
    if (st_r == ST_FIX) begin
      if (qs > 17'(tdr_pkg::DEPTH_MAX))
        wr_r <= inside_r && (tdr_pkg::DEPTH_MAX > rd_data_r);
      else if (qs < 17'(tdr_pkg::DEPTH_MIN))
        wr_r <= 1'b0;
      else
        wr_r <= inside_r && ($signed(qs[DW-1:0]) > rd_data_r);
    end
  end

  // depth store: reset sweep, read at WEIGHT, write back at WRITE
  always_comb begin
    mem_re = (st_r == ST_WEIGHT);
    if (clearing_r) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
      mem_wd = tdr_pkg::DEPTH_MIN;
    end else begin
      mem_we = (st_r == ST_WRITE) && out_free && wr_r;
      mem_wa = job_addr;
      mem_wd = d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data_r <= mem[job_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == {AW{1'b1}}) clearing_r <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((st_r == ST_WRITE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((st_r == ST_WRITE) && out_free) begin
      out_data_r <= {6'b0, (wr_r ? job_r.shade : 24'd0), job_r.py, job_r.px};
      out_last_r <= job_r.last;
      out_user_r <= wr_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  `TDR_ASSERT(a_no_out_clearing, clk, rst_n, clearing_r |-> !out_valid_r, "beat in clear")
  `TDR_ASSERT(a_div_nonzero, clk, rst_n, (st_r == ST_DIV && inside_r) |-> (dvs_r != 0), "div 0")
  `TDR_ASSERT(a_result_loaded, clk, rst_n, (st_r == ST_WRITE && out_free) |=> out_valid_r, "lost")
  `TDR_ASSERT(a_store_write, clk, rst_n, (mem_we && !clearing_r) |-> wr_r, "stray write")

endmodule

@@ rtl/triangle_depth_rasterizer.sv @@
// ----------------------------------------------------------------------------
// triangle_depth_rasterizer
// Bounding-box triangle rasterizer with barycentric depth and a depth store.
// ----------------------------------------------------------------------------
// After reset the depth store is swept to minimum depth, one cell a cycle,
// through all 262144 cells, while in_tready stays low. A load beat
// (in_tuser = 0) latches a triangle and its clamped box and gives no result.
// Each step beat (in_tuser = 1) while a box is being walked queues one pixel;
// the pixel unit then takes one pixel at a time through the queue pop, six
// setup steps (differences, edge products, cross terms, depth weights, sum,
// magnitude), the restoring divider that forms depth = num / area, the fix-up
// and the depth store write-back. A stalled result holds the unit in
// write-back. A two-entry queue sits between the beat side and the pixel
// unit, so steps are taken while a pixel is in work. Steps while no box is
// active are taken and dropped.
// ----------------------------------------------------------------------------
module triangle_depth_rasterizer (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // ax, ay, az, bx, by, bz, cx, cy, cz, shade from bit 0, zero padded
  input  logic [143:0] in_tdata,
  // cmd
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pixel_x, pixel_y, pixel_color from bit 0, zero padded
  output logic [47:0]  out_tdata,
  // last_pixel
  output logic         out_tlast,
  // write_en
  output logic         out_tuser
);

  tdr_pkg::tdr_q_stat_t q_stat;
  tdr_pkg::tdr_job_t    push_job, pop_job;
  logic                 push, pop, clearing;

  tdr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .clearing  (clearing),
    .q_stat    (q_stat),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .push      (push),
    .push_job  (push_job)
  );

  tdr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .stat     (q_stat)
  );

  tdr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .pop_job    (pop_job),
    .pop        (pop),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

@@ test/triangle_depth_rasterizer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_depth_rasterizer_test
// Self-checking bench for the depth-buffered triangle rasterizer.
// ----------------------------------------------------------------------------
// Beats are driven on the input stream. Each accepted beat goes through a
// local model of the rasterizer, which holds its own depth store. The pixel
// results that the model expects are queued. A monitor compares every output
// beat with the oldest queued pixel. The run covers a directed part and random
// triangles in four phases: no idling, input idling, output stalls, and both.
// ----------------------------------------------------------------------------
module triangle_depth_rasterizer_test;

  localparam int CYCLE_LIMIT = 3_000_000;

  typedef struct {
    logic                     we;
    logic [tdr_pkg::PX_W-1:0] px;
    logic [tdr_pkg::PY_W-1:0] py;
    logic [23:0]              col;
    logic                     last;
  } pixel_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [143:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [47:0]  out_tdata;
  logic         out_tlast;
  logic         out_tuser;

  triangle_depth_rasterizer i_dut (.*);

  always #10 clk = ~clk;

  // Local model state
  shortint      zbuf [tdr_pkg::CELLS];
  int           cur_x, cur_y, xmin, xmax, ymin, ymax;
  longint       tri_v [9];
  logic [23:0]  tri_shade;
  bit           walking;

  pixel_t       pending_pixels [$];
  int           errors = 0;
  int           cycles = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver stalls
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic longint clampv(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic bit same_side(longint v, longint r);
    return v == 0 || ((v > 0) == (r > 0));
  endfunction

  function automatic void raster_reset();
    foreach (zbuf[i]) zbuf[i] = tdr_pkg::DEPTH_MIN;
    walking = 1'b0;
  endfunction

  // Model one accepted beat; queues the pixel it yields, if any.
  function automatic void raster_beat(logic cmd, logic [143:0] d);
    longint ux, vx, wx, uy, vy, wy, mx, my, mz, ma, num, dz, idx;
    pixel_t p;
    if (cmd == tdr_pkg::CMD_LOAD) begin
      tri_v[0] = longint'($signed(d[10:0]));
      tri_v[1] = longint'($signed(d[21:11]));
      tri_v[2] = longint'($signed(d[37:22]));
      tri_v[3] = longint'($signed(d[48:38]));
      tri_v[4] = longint'($signed(d[59:49]));
      tri_v[5] = longint'($signed(d[75:60]));
      tri_v[6] = longint'($signed(d[86:76]));
      tri_v[7] = longint'($signed(d[97:87]));
      tri_v[8] = longint'($signed(d[113:98]));
      tri_shade = d[137:114];
      xmin = int'(clampv(tri_v[0] < tri_v[3] ? (tri_v[0] < tri_v[6] ? tri_v[0] : tri_v[6])
                    : (tri_v[3] < tri_v[6] ? tri_v[3] : tri_v[6]), 0, tdr_pkg::SCR_W - 1));
      xmax = int'(clampv(tri_v[0] > tri_v[3] ? (tri_v[0] > tri_v[6] ? tri_v[0] : tri_v[6])
                    : (tri_v[3] > tri_v[6] ? tri_v[3] : tri_v[6]), 0, tdr_pkg::SCR_W - 1));
      ymin = int'(clampv(tri_v[1] < tri_v[4] ? (tri_v[1] < tri_v[7] ? tri_v[1] : tri_v[7])
                    : (tri_v[4] < tri_v[7] ? tri_v[4] : tri_v[7]), 0, tdr_pkg::SCR_H - 1));
      ymax = int'(clampv(tri_v[1] > tri_v[4] ? (tri_v[1] > tri_v[7] ? tri_v[1] : tri_v[7])
                    : (tri_v[4] > tri_v[7] ? tri_v[4] : tri_v[7]), 0, tdr_pkg::SCR_H - 1));
      cur_x = xmin;
      cur_y = ymin;
      walking = (xmin < xmax) && (ymin < ymax);
      return;
    end
    if (!walking) return;
    ux = tri_v[3] - tri_v[0]; vx = tri_v[6] - tri_v[0]; wx = tri_v[0] - cur_x;
    uy = tri_v[4] - tri_v[1]; vy = tri_v[7] - tri_v[1]; wy = tri_v[1] - cur_y;
    mx = vx * wy - wx * vy;
    my = wx * uy - ux * wy;
    mz = ux * vy - vx * uy;
    ma = mz - mx - my;
    p.we = 1'b0;
    if (mz != 0 && same_side(mx, mz) && same_side(my, mz) && same_side(ma, mz)) begin
      num = tri_v[2] * ma + tri_v[5] * mx + tri_v[8] * my;
      dz = clampv(num / mz, -32768, 32767);
      idx = cur_x + cur_y * tdr_pkg::SCR_W;
      if (dz > zbuf[idx]) begin
        zbuf[idx] = shortint'(dz);
        p.we = 1'b1;
      end
    end
    p.px = cur_x[tdr_pkg::PX_W-1:0];
    p.py = cur_y[tdr_pkg::PY_W-1:0];
    p.col = p.we ? tri_shade : 24'd0;
    p.last = 1'b0;
    cur_y++;
    if (cur_y >= ymax) begin
      cur_y = ymin;
      cur_x++;
      if (cur_x >= xmax) begin
        p.last = 1'b1;
        walking = 1'b0;
      end
    end
    pending_pixels.push_back(p);
  endfunction

  // Result monitor
  always @(posedge clk) begin
    pixel_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected pixel beat %h", out_tdata);
      end else begin
        e = pending_pixels.pop_front();
        if (out_tuser !== e.we || out_tdata[8:0] !== e.px || out_tdata[17:9] !== e.py ||
            out_tdata[41:18] !== e.col || out_tlast !== e.last) begin
          errors++;
          if (errors <= 10)
            $display({"pixel mismatch: exp we=%0b x=%0d y=%0d col=%h last=%0b, ",
                      "got we=%0b x=%0d y=%0d col=%h last=%0b"},
                     e.we, e.px, e.py, e.col, e.last,
                     out_tuser, out_tdata[8:0], out_tdata[17:9], out_tdata[41:18],
                     out_tlast);
        end
      end
    end
  end

  task automatic send_beat(logic cmd, logic [143:0] d);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    raster_beat(cmd, d);
  endtask

  task automatic send_tri(int ax, int ay, int az, int bx, int by, int bz,
                          int cx, int cy, int cz, logic [23:0] shade);
    logic [143:0] d;
    d = {6'd0, shade, 16'(cz), 11'(cy), 11'(cx), 16'(bz), 11'(by), 11'(bx),
         16'(az), 11'(ay), 11'(ax)};
    send_beat(tdr_pkg::CMD_LOAD, d);
  endtask

  task automatic send_steps(int n);
    repeat (n)
      send_beat(tdr_pkg::CMD_STEP, 144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
  endtask

  task automatic test_directed();
    send_steps(1);                                             // step while idle
    send_tri(-1024, -1024, 32767, 1023, -1024, -32768, 0, 1023, 0, 24'hffffff);
    send_steps(2);                                             // huge box, then reload
    send_tri(10, 10, 100, 12, 10, 100, 10, 12, 100, 24'h123456);
    send_steps(4);                                             // full 2x2 walk
    send_tri(10, 10, 50, 12, 10, 50, 10, 12, 200, 24'habcdef); // lower and higher depth
    send_steps(4);
    send_tri(20, 20, 0, 22, 22, 0, 21, 21, 0, 24'h0f0f0f);     // degenerate
    send_steps(4);
    send_tri(30, 30, 0, 30, 33, 0, 30, 35, 0, 24'h555555);     // empty box
    send_steps(1);
    send_tri(40, 40, -32768, 42, 40, -32768, 40, 42, -32768, 24'haaaaaa);
    send_steps(4);                                             // minimum depth
  endtask

  // Mostly small triangles walked fully; some huge, broken or degenerate ones.
  task automatic test_random(int items);
    int sent, kind, bx0, by0, n, az, bz, cz;
    sent = 0;
    while (sent < items) begin
      kind = $urandom_range(99);
      bx0 = $urandom_range(530) - 10;
      by0 = $urandom_range(530) - 10;
      az = $signed(16'($urandom)); bz = $signed(16'($urandom)); cz = $signed(16'($urandom));
      if (kind < 6)
        send_tri($signed(11'($urandom)), $signed(11'($urandom)), az,
                 $signed(11'($urandom)), $signed(11'($urandom)), bz,
                 $signed(11'($urandom)), $signed(11'($urandom)), cz, 24'($urandom));
      else if (kind < 11)
        send_tri(bx0, by0, az, bx0 + 3, by0 + 3, bz, bx0 + 6, by0 + 6, cz, 24'($urandom));
      else
        send_tri(bx0 + $urandom_range(6), by0 + $urandom_range(6), az,
                 bx0 + $urandom_range(6), by0 + $urandom_range(6), bz,
                 bx0 + $urandom_range(6), by0 + $urandom_range(6), cz, 24'($urandom));
      n = walking ? (xmax - xmin) * (ymax - ymin) : 0;
      if (kind < 6 || $urandom_range(9) == 0) n = $urandom_range(5);
      else if ($urandom_range(9) == 0) n = n + $urandom_range(2, 1);
      send_steps(n);
      sent += n + 1;
    end
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    raster_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    set_idling(0, 0);   test_random(150);
    set_idling(52, 0);  test_random(150);
    set_idling(0, 52);  test_random(150);
    set_idling(29, 29); test_random(150);
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/tdr_pkg.sv
rtl/tdr_queue.sv
rtl/tdr_front.sv
rtl/tdr_back.sv
rtl/triangle_depth_rasterizer.sv
test/triangle_depth_rasterizer_test.sv
